>>> sv/ictf_pkg.sv
// Shared constants, register indexes and the CORDIC angle table of the tilt filter.
`timescale 1ns / 1ps
package ictf_pkg;

	localparam int CORDIC_ITERATIONS_DEF = 16;
	localparam int ROT_TABLE_LEN = 24;
	localparam int ROT_IDX_W = $clog2(ROT_TABLE_LEN);

	// +-90 degrees in Q.16
	localparam logic signed [23:0] ANG_LIMIT = 24'sd5898240;

	localparam logic [16:0] ACCEL_WEIGHT_X_RST = 17'd62259;
	localparam logic [16:0] ACCEL_WEIGHT_Y_RST = 17'd58982;
	localparam logic signed [15:0] CROSS_GAIN_X_RST = -16'sd1280;
	localparam logic signed [15:0] CROSS_GAIN_Y_RST = 16'sd2560;
	localparam logic [31:0] GYRO_STEP_GAIN_RST = 32'd315076;

	localparam logic [2:0] REG_ACCEL_WEIGHT_X = 3'd0;
	localparam logic [2:0] REG_ACCEL_WEIGHT_Y = 3'd1;
	localparam logic [2:0] REG_CROSS_GAIN_X = 3'd2;
	localparam logic [2:0] REG_CROSS_GAIN_Y = 3'd3;
	localparam logic [2:0] REG_GYRO_STEP_GAIN = 3'd4;

	// atan(2^-i) in degrees, Q.16
	function automatic logic [21:0] rot_angle(input logic [ROT_IDX_W-1:0] idx);
		logic [21:0] a;
		case (idx)
			5'd0: a = 22'd2949120;
			5'd1: a = 22'd1740967;
			5'd2: a = 22'd919879;
			5'd3: a = 22'd466945;
			5'd4: a = 22'd234379;
			5'd5: a = 22'd117304;
			5'd6: a = 22'd58666;
			5'd7: a = 22'd29335;
			5'd8: a = 22'd14668;
			5'd9: a = 22'd7334;
			5'd10: a = 22'd3667;
			5'd11: a = 22'd1833;
			5'd12: a = 22'd917;
			5'd13: a = 22'd458;
			5'd14: a = 22'd229;
			5'd15: a = 22'd115;
			5'd16: a = 22'd57;
			5'd17: a = 22'd29;
			5'd18: a = 22'd14;
			5'd19: a = 22'd7;
			5'd20: a = 22'd4;
			5'd21: a = 22'd2;
			5'd22: a = 22'd1;
			default: a = 22'd0;
		endcase
		return a;
	endfunction

endpackage

>>> sv/imu_tilt_complementary_filter.sv
// Top level of the complementary tilt filter: sequencer, square root, integrator and blend.
`timescale 1ns / 1ps
// One word on s_tdata is one filter tick; one word on m_tdata follows it. A tick runs
// the squares on the multiplier, then two 16-step square roots and two CORDIC runs (a run
// skips its iterations when a denominator is zero), done one axis after the other, then
// the gyro integration and the two blends on the shared 18 x 33 multiplier, the load of
// the output register and the return to idle.
// The block takes no new word until the result is loaded into the output register.
// Configuration writes are taken at any time and belong in the idle gaps between ticks.
module imu_tilt_complementary_filter import ictf_pkg::*; #(
	parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // accel_x, accel_y, accel_z, rate_x, rate_y
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // tilt_x, tilt_y
	output logic        m_tuser,   // saturated
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	typedef enum logic [2:0] {S_IDLE, S_SQR, S_ROOT, S_ATAN, S_POST, S_OUT} state_t;

	state_t state_q;
	logic [3:0] step_q;
	logic axis_q;

	logic [16:0] weight_x_q, weight_y_q;
	logic signed [15:0] gain_x_q, gain_y_q;
	logic [31:0] step_gain_q;

	logic signed [15:0] ax_q, ay_q, az_q, rx_q, ry_q;
	logic signed [47:0] gx_q, gy_q;

	logic signed [17:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [50:0] prod_q;

	logic [31:0] sq_az_q, ny_q;
	logic [31:0] rem_q, root_q, bit_q;
	logic [32:0] trial;

	logic start_q;
	logic cordic_done;
	logic signed [23:0] cordic_angle;
	logic signed [23:0] theta_x_q, theta_y_q;

	logic signed [65:0] acc_q, rnd_sum;
	logic signed [33:0] rnd;
	logic rnd_sat;
	logic [31:0] rnd_val;
	logic signed [49:0] int_sum;
	logic int_sat;
	logic signed [47:0] int_val, g_sel;
	logic sat_q;
	logic [31:0] tilt_x_q, tilt_y_q;

	logic m_tvalid_q;
	logic [63:0] m_tdata_q;
	logic m_tuser_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_x_q <= ACCEL_WEIGHT_X_RST;
			weight_y_q <= ACCEL_WEIGHT_Y_RST;
			gain_x_q <= CROSS_GAIN_X_RST;
			gain_y_q <= CROSS_GAIN_Y_RST;
			step_gain_q <= GYRO_STEP_GAIN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ACCEL_WEIGHT_X: weight_x_q <= cfg_data[16:0];
				REG_ACCEL_WEIGHT_Y: weight_y_q <= cfg_data[16:0];
				REG_CROSS_GAIN_X: gain_x_q <= signed'(cfg_data[15:0]);
				REG_CROSS_GAIN_Y: gain_y_q <= signed'(cfg_data[15:0]);
				REG_GYRO_STEP_GAIN: step_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQR: begin
				case (step_q)
					4'd0: begin
						mul_a = {{2{az_q[15]}}, az_q};
						mul_b = {{17{az_q[15]}}, az_q};
					end
					4'd1: begin
						mul_a = {{2{ay_q[15]}}, ay_q};
						mul_b = {{17{ay_q[15]}}, ay_q};
					end
					default: begin
						mul_a = {{2{ax_q[15]}}, ax_q};
						mul_b = {{17{ax_q[15]}}, ax_q};
					end
				endcase
			end
			S_POST: begin
				case (step_q)
					4'd0: begin
						mul_a = {{2{rx_q[15]}}, rx_q};
						mul_b = {1'b0, step_gain_q};
					end
					4'd1: begin
						mul_a = {{2{ry_q[15]}}, ry_q};
						mul_b = {1'b0, step_gain_q};
					end
					4'd2: begin
						mul_a = {1'b0, weight_x_q};
						mul_b = {{9{theta_x_q[23]}}, theta_x_q};
					end
					4'd3: begin
						mul_a = {{2{gain_x_q[15]}}, gain_x_q};
						mul_b = {{9{gy_q[47]}}, gy_q[47:24]};
					end
					4'd4: begin
						mul_a = {{2{gain_x_q[15]}}, gain_x_q};
						mul_b = {9'd0, gy_q[23:0]};
					end
					4'd5: begin
						mul_a = {1'b0, weight_y_q};
						mul_b = {{9{theta_y_q[23]}}, theta_y_q};
					end
					4'd6: begin
						mul_a = {{2{gain_y_q[15]}}, gain_y_q};
						mul_b = {{9{gx_q[47]}}, gx_q[47:24]};
					end
					4'd7: begin
						mul_a = {{2{gain_y_q[15]}}, gain_y_q};
						mul_b = {9'd0, gx_q[23:0]};
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		trial = {1'b0, root_q} + {1'b0, bit_q};

		g_sel = (step_q == 4'd1) ? gx_q : gy_q;
		int_sum = {{2{g_sel[47]}}, g_sel} + prod_q[49:0];
		int_sat = (int_sum[49:47] != 3'b000) && (int_sum[49:47] != 3'b111);
		if (!int_sat) int_val = int_sum[47:0];
		else if (int_sum[49]) int_val = {1'b1, 47'd0};
		else int_val = {1'b0, {47{1'b1}}};

		// Add one half, then floor to Q.8.
		rnd_sum = acc_q + (66'sd1 <<< 31);
		rnd = rnd_sum[65:32];
		rnd_sat = (rnd[33:31] != 3'b000) && (rnd[33:31] != 3'b111);
		if (!rnd_sat) rnd_val = rnd[31:0];
		else if (rnd[33]) rnd_val = {1'b1, 31'd0};
		else rnd_val = {1'b0, {31{1'b1}}};
	end

	ictf_cordic #(.ITERS(CORDIC_ITERATIONS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.num    (axis_q ? ay_q : ax_q),
		.den    (root_q[15:0]),
		.done   (cordic_done),
		.angle  (cordic_angle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			axis_q <= 1'b0;
			start_q <= 1'b0;
			gx_q <= '0;
			gy_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			prod_q <= mul_a * mul_b;
			start_q <= 1'b0;
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						ax_q <= signed'(s_tdata[15:0]);
						ay_q <= signed'(s_tdata[31:16]);
						az_q <= signed'(s_tdata[47:32]);
						rx_q <= signed'(s_tdata[63:48]);
						ry_q <= signed'(s_tdata[79:64]);
						step_q <= '0;
						axis_q <= 1'b0;
						sat_q <= 1'b0;
						state_q <= S_SQR;
					end
				end
				S_SQR: begin
					step_q <= step_q + 1'b1;
					unique case (step_q)
						4'd0: ;
						4'd1: sq_az_q <= prod_q[31:0];
						4'd2: begin
							rem_q <= prod_q[31:0] + sq_az_q;
							root_q <= '0;
							bit_q <= 32'h4000_0000;
						end
						default: begin
							ny_q <= prod_q[31:0] + sq_az_q;
							state_q <= S_ROOT;
						end
					endcase
				end
				S_ROOT: begin
					if ({1'b0, rem_q} >= trial) begin
						rem_q <= rem_q - trial[31:0];
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q == 32'd1) begin
						start_q <= 1'b1;
						state_q <= S_ATAN;
					end
				end
				S_ATAN: begin
					if (cordic_done) begin
						if (!axis_q) begin
							theta_x_q <= cordic_angle;
							axis_q <= 1'b1;
							rem_q <= ny_q;
							root_q <= '0;
							bit_q <= 32'h4000_0000;
							state_q <= S_ROOT;
						end else begin
							theta_y_q <= cordic_angle;
							step_q <= '0;
							state_q <= S_POST;
						end
					end
				end
				S_POST: begin
					step_q <= step_q + 1'b1;
					case (step_q)
						4'd1: begin
							gx_q <= int_val;
							if (int_sat) sat_q <= 1'b1;
						end
						4'd2: begin
							gy_q <= int_val;
							if (int_sat) sat_q <= 1'b1;
						end
						4'd3, 4'd6: begin
							if (step_q == 4'd6) begin
								tilt_x_q <= rnd_val;
								if (rnd_sat) sat_q <= 1'b1;
							end
							acc_q <= {{16{prod_q[41]}}, prod_q[41:0], 8'd0};
						end
						4'd4, 4'd7: acc_q <= acc_q + {prod_q[41:0], 24'd0};
						4'd5, 4'd8: acc_q <= acc_q + {{15{prod_q[50]}}, prod_q};
						4'd9: begin
							tilt_y_q <= rnd_val;
							if (rnd_sat) sat_q <= 1'b1;
							state_q <= S_OUT;
						end
						default: ;
					endcase
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q <= {tilt_y_q, tilt_x_q};
						m_tuser_q <= sat_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

endmodule

>>> sv/ictf_cordic.sv
// Iterative vectoring CORDIC giving atan2(num, den) in Q.16 degrees, clamped to +-90.
`timescale 1ns / 1ps
module ictf_cordic import ictf_pkg::*; #(
	parameter int ITERS = CORDIC_ITERATIONS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [15:0]  num,
	input  logic [15:0]         den,
	output logic                done,
	output logic signed [23:0]  angle
);

	localparam int N = (ITERS > ROT_TABLE_LEN) ? ROT_TABLE_LEN : ITERS;
	localparam logic [ROT_IDX_W-1:0] LAST = ROT_IDX_W'(N - 1);

	logic signed [35:0] x_q, y_q, xs, ys, x_n, y_n;
	logic signed [24:0] z_q, z_n, ang;
	logic [ROT_IDX_W-1:0] i_q;
	logic busy_q, done_q;
	logic signed [23:0] angle_q;

	always_comb begin
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		ang = signed'({3'b000, rot_angle(i_q)});
		if (!y_q[35]) begin
			x_n = x_q + ys;
			y_n = y_q - xs;
			z_n = z_q + ang;
		end else begin
			x_n = x_q - ys;
			y_n = y_q + xs;
			z_n = z_q - ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (den == 16'd0) begin
					// Vertical vector: the angle is a signed right angle, or zero.
					if (num > 16'sd0) angle_q <= ANG_LIMIT;
					else if (num < 16'sd0) angle_q <= -ANG_LIMIT;
					else angle_q <= 24'sd0;
					done_q <= 1'b1;
				end else begin
					x_q <= signed'({4'b0000, den, 16'h0000});
					y_q <= signed'({{4{num[15]}}, num, 16'h0000});
					z_q <= 25'sd0;
					i_q <= '0;
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				x_q <= x_n;
				y_q <= y_n;
				z_q <= z_n;
				i_q <= i_q + 1'b1;
				if (i_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					if (z_n > 25'(ANG_LIMIT)) angle_q <= ANG_LIMIT;
					else if (z_n < -25'(ANG_LIMIT)) angle_q <= -ANG_LIMIT;
					else angle_q <= z_n[23:0];
				end
			end
		end
	end

	assign done = done_q;
	assign angle = angle_q;

endmodule
